/* sv/upq_pkg.sv */
// ----------------------------------------------------------------------------
// upq_pkg
// Shared constants and types of the unsorted priority queue.
// ----------------------------------------------------------------------------
package upq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_TAKE  = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_COUNT = 3'd3,
    KIND_EXIST = 3'd4,
    KIND_TALL  = 3'd5
  } kind_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // one memory word: priority above value
  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic        we;
    logic [IdxW-1:0] waddr;
    entry_t      wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic signed [15:0] prio;
    logic [4:0]         tally;
    logic               last;
  } result_t;

endpackage

/* sv/upq_ram.sv */
// ----------------------------------------------------------------------------
// upq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module upq_ram
  import upq_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

/* sv/upq_ctrl.sv */
// ----------------------------------------------------------------------------
// upq_ctrl
// Sequencer: scans the store one entry a cycle, pausing at take-all results,
// compacts it on removal, hands result items to a one-deep output register.
// ----------------------------------------------------------------------------
module upq_ctrl
  import upq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [15:0] prio_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_o,
  output mem_req_t    mem_o,
  input  entry_t      rdata_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,  // read pass: highest, count, exist, match count
    ST_EMIT  = 7'b0000100,  // post single result
    ST_SHIFT = 7'b0001000,  // compaction pass from a start index
    ST_TALL  = 7'b0010000,  // take-all filter pass
    ST_TWAIT = 7'b0100000,  // wait for output slot
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]  kind_q;
  logic [31:0] val_q;
  logic [15:0] pri_q;
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] rd_q, rd_d;     // next read index
  logic [CntW-1:0] wr_q, wr_d;     // compaction write index
  logic            rv_q, rv_d;     // read data valid this cycle
  logic [CntW-1:0] ri_q, ri_d;     // index of data arriving
  logic [CntW-1:0] best_q, best_d;
  entry_t          bent_q, bent_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] k_q, k_d;
  logic            hit_q, hit_d;
  entry_t          pend_q, pend_d;
  logic            ov_q;
  result_t         ob_q;
  logic            push;
  result_t         pres;
  logic            slot;

  assign slot        = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_o       = ob_q;

  function automatic logic [4:0] sat5(input logic [CntW-1:0] v);
    return (CntW > 5 && v > CntW'(31)) ? 5'd31 : 5'(v);
  endfunction

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    rv_d    = 1'b0;
    ri_d    = rd_q;
    best_d  = best_q;
    bent_d  = bent_q;
    n_d     = n_q;
    k_d     = k_q;
    hit_d   = hit_q;
    pend_d  = pend_q;
    push    = 1'b0;
    pres    = '0;
    pres.last = 1'b1;
    mem_o   = '0;
    mem_o.raddr = rd_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_d  = '0;
          n_d   = '0;
          k_d   = '0;
          hit_d = 1'b0;
          best_d = '0;
          state_d = ST_SCAN;
          case (kind_i)
            KIND_ADD: begin
              state_d = ST_EMIT;
              if (occ_q != CntW'(Capacity)) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = occ_q[IdxW-1:0];
                mem_o.wdata = '{prio: prio_i, value: value_i};
                occ_d = occ_q + 1'b1;
                hit_d = 1'b1;
              end
            end
            KIND_TAKE, KIND_PEEK, KIND_COUNT, KIND_EXIST, KIND_TALL: ;
            default: state_d = ST_EMIT;
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_q < occ_q) begin
          rv_d = 1'b1;
          rd_d = rd_q + 1'b1;
        end
        if (rv_q) begin
          case (kind_q)
            KIND_TAKE, KIND_PEEK: begin
              if (ri_q == '0 || $signed(rdata_i.prio) > $signed(bent_q.prio)) begin
                best_d = ri_q;
                bent_d = rdata_i;
              end
            end
            KIND_EXIST: begin
              if (rdata_i.value == val_q && (pri_q == '0 || rdata_i.prio == pri_q))
                hit_d = 1'b1;
            end
            default: begin
              if (rdata_i.prio == pri_q) n_d = n_q + 1'b1;
            end
          endcase
        end
        if (!rv_q && rd_q >= occ_q && !(rd_q < occ_q)) begin
          state_d = ST_EMIT;
        end else if (rv_q && rd_q >= occ_q) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot) begin
          push = 1'b1;
          case (kind_q)
            KIND_ADD:   pres.status = hit_q ? STAT_OK : STAT_FULL;
            KIND_TAKE, KIND_PEEK: begin
              if (occ_q == '0) pres.status = STAT_EMPTY;
              else begin
                pres.value = bent_q.value;
                pres.prio  = bent_q.prio;
              end
            end
            KIND_COUNT: pres.tally = sat5(pri_q == '0 ? occ_q : n_q);
            KIND_EXIST: pres.status = hit_q ? STAT_OK : STAT_EMPTY;
            KIND_TALL:  pres.status = STAT_EMPTY;
            default:    pres.status = STAT_EMPTY;
          endcase
          state_d = ST_DONE;
          if (kind_q == KIND_TAKE && occ_q != '0) begin
            state_d = ST_SHIFT;
            wr_d = best_q;
            rd_d = best_q + 1'b1;
          end else if (kind_q == KIND_TALL && n_q != '0) begin
            push  = 1'b0;
            state_d = ST_TALL;
            rd_d = '0;
            wr_d = '0;
          end
        end
      end

      ST_SHIFT: begin
        if (rd_q < occ_q) begin
          rv_d = 1'b1;
          rd_d = rd_q + 1'b1;
        end
        if (rv_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wr_q[IdxW-1:0];
          mem_o.wdata = rdata_i;
          wr_d = wr_q + 1'b1;
        end
        if (rd_q >= occ_q && !rv_q) begin
          occ_d = occ_q - 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_TALL: begin
        if (rv_q && rdata_i.prio == pri_q) begin
          pend_d  = rdata_i;
          state_d = ST_TWAIT;
        end else begin
          if (rv_q) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = wr_q[IdxW-1:0];
            mem_o.wdata = rdata_i;
            wr_d = wr_q + 1'b1;
          end
          if (rd_q < occ_q) begin
            rv_d = 1'b1;
            rd_d = rd_q + 1'b1;
          end else if (!rv_q) begin
            occ_d = occ_q - n_q;
            state_d = ST_DONE;
          end
        end
      end

      ST_TWAIT: begin
        if (slot) begin
          push = 1'b1;
          pres.value = pend_q.value;
          pres.prio  = pend_q.prio;
          pres.tally = sat5(n_q);
          pres.last  = (k_q + 1'b1 == n_q);
          k_d = k_q + 1'b1;
          state_d = ST_TALL;
          if (rd_q < occ_q) begin
            rv_d = 1'b1;
            rd_d = rd_q + 1'b1;
          end else begin
            occ_d = occ_q - n_q;
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: state_d = ST_IDLE;

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      rv_q    <= 1'b0;
      ri_q    <= '0;
      n_q     <= '0;
      k_q     <= '0;
      hit_q   <= 1'b0;
      best_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      rv_q    <= rv_d;
      ri_q    <= ri_d;
      n_q     <= n_d;
      k_q     <= k_d;
      hit_q   <= hit_d;
      best_q  <= best_d;
      if (push) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bent_q <= bent_d;
    pend_q <= pend_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      kind_q <= kind_i;
      val_q  <= value_i;
      pri_q  <= prio_i;
    end
    if (push) ob_q <= pres;
  end

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Capacity)) else $error("occupancy above capacity");
  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> slot) else $error("result overwritten");
  a_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT || state_q == ST_TALL) |-> wr_q <= rd_q)
    else $error("compaction write ahead of read");
  a_idle_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.we && state_q != ST_IDLE) |-> (state_q == ST_SHIFT || state_q == ST_TALL))
    else $error("stray store write");

endmodule

/* sv/unsorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// unsorted_priority_queue
// Fixed-capacity value/priority store in insertion order, one RAM and a
// sequencer doing scan and compaction passes.
//
//  channel  | dir | tdata (low bit up)                        | tuser / tlast
//  s_axis   | in  | value[31:0] priority[47:32]               | tuser = kind[2:0]
//  m_axis   | out | value[31:0] priority[47:32] tally[52:48]  | tuser = status[1:0]
//           |     |                                           | tlast = last
//
//  Add and unknown kinds need no scan; the other kinds scan the store once.
//  Take adds a compaction pass over the entries behind the taken one, and
//  take-all streams through the store once, one entry a cycle, pausing
//  at each result until it is posted.
//  All cost is set by the single read port of the entry RAM.
//  Reset empties the store at once; no clearing pass.
//  An output stall holds the sequencer at the next result.
// ----------------------------------------------------------------------------
module unsorted_priority_queue
  import upq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // item_value, item_priority
  input  logic [2:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_value, out_priority, tally
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // last
);

  mem_req_t mem_req;
  entry_t   rdata;
  result_t  res;

  upq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  upq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[31:0]),
    .prio_i      (s_axis_tdata[47:32]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

  assign m_axis_tdata = {3'b000, res.tally, res.prio, res.value};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Regression of the unsorted priority queue: a behavioral model of the store
// predicts every result item, a monitor compares each one on the output stream.
// ----------------------------------------------------------------------------
module tb;
  import upq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCycles = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  unsorted_priority_queue DUT (.*);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [15:0] prio;
    logic [4:0]  tally;
    logic        last;
  } res_t;

  logic [31:0] st_val [Capacity];
  logic [15:0] st_pri [Capacity];
  int          st_cnt;
  res_t        pending_q[$];
  int          n_fail, n_items, n_results, cycles;
  int          src_idle, snk_idle;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("unsorted_priority_queue regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  function automatic res_t mk(logic [1:0] s, logic [31:0] v, logic [15:0] p,
                              int t, logic l);
    res_t r;
    r.status = s; r.value = v; r.prio = p;
    r.tally = (t > 31) ? 5'd31 : t[4:0]; r.last = l;
    return r;
  endfunction

  task automatic drop_entry(int idx);
    for (int i = idx; i + 1 < st_cnt; i++) begin
      st_val[i] = st_val[i+1];
      st_pri[i] = st_pri[i+1];
    end
    st_cnt--;
  endtask

  task automatic predict_queue(logic [2:0] k, logic [31:0] v, logic [15:0] p);
    int best, n, i, got;
    case (k)
      KIND_ADD: begin
        if (st_cnt >= Capacity) pending_q.push_back(mk(STAT_FULL, 0, 0, 0, 1));
        else begin
          st_val[st_cnt] = v; st_pri[st_cnt] = p; st_cnt++;
          pending_q.push_back(mk(STAT_OK, 0, 0, 0, 1));
        end
      end
      KIND_TAKE, KIND_PEEK: begin
        if (st_cnt == 0) pending_q.push_back(mk(STAT_EMPTY, 0, 0, 0, 1));
        else begin
          best = 0;
          for (i = 1; i < st_cnt; i++)
            if ($signed(st_pri[i]) > $signed(st_pri[best])) best = i;
          pending_q.push_back(mk(STAT_OK, st_val[best], st_pri[best], 0, 1));
          if (k == KIND_TAKE) drop_entry(best);
        end
      end
      KIND_COUNT: begin
        n = 0;
        for (i = 0; i < st_cnt; i++) if (p == 0 || st_pri[i] == p) n++;
        pending_q.push_back(mk(STAT_OK, 0, 0, n, 1));
      end
      KIND_EXIST: begin
        n = 0;
        for (i = 0; i < st_cnt; i++)
          if (st_val[i] == v && (p == 0 || st_pri[i] == p)) n = 1;
        pending_q.push_back(mk(n ? STAT_OK : STAT_EMPTY, 0, 0, 0, 1));
      end
      KIND_TALL: begin
        n = 0;
        for (i = 0; i < st_cnt; i++) if (st_pri[i] == p) n++;
        if (n == 0) pending_q.push_back(mk(STAT_EMPTY, 0, 0, 0, 1));
        else begin
          got = 0; i = 0;
          while (i < st_cnt) begin
            if (st_pri[i] == p) begin
              got++;
              pending_q.push_back(mk(STAT_OK, st_val[i], p, n, got == n));
              drop_entry(i);
            end else i++;
          end
        end
      end
      default: pending_q.push_back(mk(STAT_EMPTY, 0, 0, 0, 1));
    endcase
  endtask

  always @(posedge clk_i) begin
    res_t act, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
             m_axis_tdata[52:48], m_axis_tlast};
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", act);
        n_fail++;
      end else begin
        exp_r = pending_q.pop_front();
        if (act.status !== exp_r.status) begin
          $error("status exp %0d act %0d", exp_r.status, act.status); n_fail++;
        end
        if (act.value !== exp_r.value) begin
          $error("out_value exp %h act %h", exp_r.value, act.value); n_fail++;
        end
        if (act.prio !== exp_r.prio) begin
          $error("out_priority exp %h act %h", exp_r.prio, act.prio); n_fail++;
        end
        if (act.tally !== exp_r.tally) begin
          $error("tally exp %0d act %0d", exp_r.tally, act.tally); n_fail++;
        end
        if (act.last !== exp_r.last) begin
          $error("last exp %0d act %0d", exp_r.last, act.last); n_fail++;
        end
      end
    end
  end

  task automatic send_op(logic [2:0] k, logic [31:0] v, logic [15:0] p);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p, v};
    s_axis_tuser  <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_queue(k, v, p);
    n_items++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_op(KIND_TAKE, 0, 0);
    send_op(KIND_PEEK, 0, 0);
    send_op(KIND_TALL, 0, 0);
    send_op(KIND_ADD, 32'h7fffffff, 16'h7fff);
    send_op(KIND_ADD, 32'h80000000, 16'h8000);
    send_op(KIND_ADD, 32'hffffffff, 16'h0000);
    send_op(KIND_ADD, 32'h00000000, 16'h7fff);
    send_op(KIND_PEEK, 0, 0);
    send_op(KIND_COUNT, 0, 0);
    send_op(KIND_COUNT, 0, 16'h7fff);
    send_op(KIND_EXIST, 32'hffffffff, 0);
    send_op(KIND_EXIST, 32'hffffffff, 16'h8000);
    send_op(KIND_TALL, 0, 16'h0000);
    send_op(KIND_TAKE, 0, 0);
    send_op(3'd6, 32'hffffffff, 16'hffff);
    send_op(3'd7, 0, 0);
    for (int i = 0; i < 14; i++) send_op(KIND_ADD, i, 16'h0005);
    send_op(KIND_ADD, 32'h1234, 16'h0005);
    send_op(KIND_TALL, 0, 16'h0005);
    send_op(KIND_TAKE, 0, 0);
    wait_drain();
  endtask

  task automatic test_random(int n);
    logic [2:0]  k;
    logic [31:0] v;
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      k = (i % 10 < 4) ? KIND_ADD : 3'($urandom_range(7));
      v = ($urandom_range(1)) ? $urandom : 32'($urandom_range(3));
      p = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      send_op(k, v, p);
      if (i == n / 2) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 0;
    st_cnt = 0; n_fail = 0; n_items = 0; n_results = 0; cycles = 0;
    src_idle = 22; snk_idle = 59;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(26);
    src_idle = 59; snk_idle = 22;
    test_random(26);
    src_idle = 0; snk_idle = 0;
    test_random(26);
    $display("covered %0d items and %0d results over add, take, peek, count,",
             n_items, n_results);
    $display("exist, take-all, unknown kinds, full and empty store");
    if (n_fail == 0) $display("unsorted_priority_queue regression: pass");
    else $display("unsorted_priority_queue regression: fail");
    $finish;
  end
endmodule
